/* sv/vlcs_pkg.sv */
`default_nettype none

package vlcs_pkg;

    // round-robin buffer rotation
    localparam int BUF_COUNT = 4;
    localparam int BUF_W     = (BUF_COUNT > 1) ? $clog2(BUF_COUNT) : 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_LINE  = 2'd1;

    localparam logic [15:0] SWAP_LINE_RST = 16'd20;
    localparam logic [15:0] CNT16_MAX     = 16'hFFFF;
    localparam logic [31:0] CNT32_MAX     = 32'hFFFF_FFFF;
    localparam logic [15:0] FIELD_MIN     = 16'd256;
    localparam logic [15:0] FRAME_MIN     = 16'd512;

    // sample conditioning limits
    localparam logic [11:0] WAVE_HI  = 12'd3327;
    localparam logic [11:0] WAVE_LO  = 12'd1279;
    localparam logic [10:0] WAVE_MAX = 11'd1023;
    localparam logic [11:0] CV_FLOOR = 12'd32;
    localparam logic [10:0] CV_MAX   = 11'd709;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_FIRST = 2'd1,
        EV_FRAME = 2'd2
    } t_field_event;

    typedef enum logic [1:0] {
        SM_RAW,
        SM_PAIR,
        SM_QUAD
    } t_smooth_mode;

    typedef struct packed {
        logic         en;
        t_smooth_mode mode;
    } t_smooth_ctl;

    function automatic logic [BUF_W-1:0] next_buf(input logic [BUF_W-1:0] idx);
        logic [BUF_W-1:0] r;
        if (idx == BUF_W'(BUF_COUNT - 1)) begin
            r = '0;
        end else begin
            r = idx + 1'b1;
        end
        return r;
    endfunction

    // invert, clamp to the useful window, remove the low offset, halve, cap
    function automatic logic [9:0] wave_cond(input logic [11:0] adc);
        logic [11:0] s;
        logic [11:0] d;
        logic [10:0] h;
        s = ~adc;
        if (s >= WAVE_HI) begin
            s = WAVE_HI;
        end else if (s <= WAVE_LO) begin
            s = WAVE_LO;
        end
        d = s - WAVE_LO;
        h = d[11:1];
        if (h > WAVE_MAX) begin
            h = WAVE_MAX;
        end
        return h[9:0];
    endfunction

    // weighted average of three inverted readings, floored, halved, capped
    function automatic logic [9:0] cv_cond(input logic [11:0] a,
                                           input logic [11:0] b,
                                           input logic [11:0] c);
        logic [12:0] sum;
        logic [11:0] v;
        logic [10:0] h;
        sum = {1'b0, ~a} + {1'b0, ~b};
        v   = sum[12:1];
        sum = {1'b0, v} + {1'b0, ~c};
        v   = sum[12:1];
        if (v <= CV_FLOOR) begin
            v = CV_FLOOR;
        end
        h = v[11:1];
        if (h >= CV_MAX) begin
            h = CV_MAX;
        end
        return h[9:0];
    endfunction

endpackage

`default_nettype wire

/* sv/vlcs_smooth.sv */
`default_nettype none

module vlcs_smooth (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  vlcs_pkg::t_smooth_ctl   i_ctl,
    input  wire  [9:0]              i_value,
    output logic [9:0]              o_result
);

    logic [9:0]  r_hist [3];
    logic [10:0] pair_sum;
    logic [11:0] quad_sum;

    assign pair_sum = {1'b0, i_value} + {1'b0, r_hist[0]};
    assign quad_sum = {2'b00, i_value} + {2'b00, r_hist[0]}
                    + {2'b00, r_hist[1]} + {2'b00, r_hist[2]};

    always_comb begin
        case (i_ctl.mode)
            vlcs_pkg::SM_RAW:  o_result = i_value;
            vlcs_pkg::SM_PAIR: o_result = pair_sum[10:1];
            vlcs_pkg::SM_QUAD: o_result = quad_sum[11:2];
            default:           o_result = i_value;
        endcase
    end

    // entry 0 is the newest stored value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist[0] <= '0;
            r_hist[1] <= '0;
            r_hist[2] <= '0;
        end else if (i_ctl.en) begin
            r_hist[2] <= r_hist[1];
            r_hist[1] <= r_hist[0];
            r_hist[0] <= o_result;
        end
    end

endmodule

`default_nettype wire

/* sv/video_line_capture_sequencer.sv */
// channel  | beat            | handshake
// ---------+-----------------+---------------------------
// in       | one hsync line  | i_in_valid / o_in_stall
// out      | one line result | o_out_valid / i_out_stall
// cfg      | register write  | i_cfg_we (no wait)
//
// one line per clock unless output stalls; input register feeds the result register.
// the line and frame counters, buffer indices and smoothing history update in the
// cycle the line moves from the input register into the result register.
// i_rst_n is synchronous; it clears counters, indices, history and valid flags.
// an output stall holds the result and any queued line; input stalls only when both full.
`default_nettype none

module video_line_capture_sequencer (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [vlcs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [15:0]                           i_cfg_data,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire                                   i_field_id,
    input  wire                                   i_vsync_active,
    input  wire  [11:0]                           i_wave_adc,
    input  wire  [11:0]                           i_cv_adc_first,
    input  wire  [11:0]                           i_cv_adc_second,
    input  wire  [11:0]                           i_cv_adc_third,
    input  wire                                   i_trigger_level,
    input  wire                                   i_render_done,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic [15:0]                           o_line_index,
    output logic [1:0]                            o_sample_buffer,
    output logic [9:0]                            o_wave_value,
    output logic [9:0]                            o_cv_value,
    output logic [1:0]                            o_wave_read_buffer,
    output logic [1:0]                            o_sample_read_buffer,
    output logic [1:0]                            o_field_event,
    output logic [15:0]                           o_lines_first_field,
    output logic [15:0]                           o_lines_second_field,
    output logic [31:0]                           o_missed_swaps,
    output logic [7:0]                            o_trigger_rises,
    output logic [7:0]                            o_trigger_falls
);

    localparam int BW = vlcs_pkg::BUF_W;

    // configuration
    logic        r_capture_en;
    logic [15:0] r_swap_line;

    // input register
    logic        r_iv;
    logic        r_fid;
    logic        r_vs;
    logic [11:0] r_wadc;
    logic [11:0] r_ca;
    logic [11:0] r_cb;
    logic [11:0] r_cc;
    logic        r_trig;
    logic        r_rdone;

    // line state
    logic          r_field_seen;
    logic [15:0]   r_frame_cnt;
    logic [15:0]   r_line_cnt;
    logic [BW-1:0] r_smp_wr;
    logic [BW-1:0] r_smp_rd;
    logic [BW-1:0] r_wav_wr;
    logic [BW-1:0] r_wav_rd;
    logic          r_render_flag;
    logic [31:0]   r_dropped;
    logic [15:0]   r_first_lines;
    logic [15:0]   r_second_lines;
    logic          r_trig_prev;
    logic [7:0]    r_rises;
    logic [7:0]    r_falls;

    // result register
    logic          r_ov;

    logic          adv;
    logic          fire;
    logic          swap;
    logic [15:0]   line_inc;
    logic [15:0]   frame_inc;

    logic          n_field_seen;
    logic [15:0]   n_frame_cnt;
    logic [15:0]   n_line_cnt;
    logic [BW-1:0] n_smp_wr;
    logic [BW-1:0] n_smp_rd;
    logic [BW-1:0] n_wav_wr;
    logic [BW-1:0] n_wav_rd;
    logic          n_render_flag;
    logic [31:0]   n_dropped;
    logic [15:0]   n_first_lines;
    logic [15:0]   n_second_lines;
    logic [7:0]    n_rises;
    logic [7:0]    n_falls;
    vlcs_pkg::t_field_event n_event;

    vlcs_pkg::t_smooth_ctl smooth_ctl;
    logic [9:0]    wave_cond;
    logic [9:0]    cv_cond;
    logic [9:0]    wave_sm;
    logic [9:0]    cv_sm;

    assign adv        = !r_ov || !i_out_stall;
    assign fire       = r_iv && adv;
    assign o_in_stall = r_iv && !adv;
    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capture_en <= 1'b1;
            r_swap_line  <= vlcs_pkg::SWAP_LINE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vlcs_pkg::CFG_CAPTURE_EN: r_capture_en <= i_cfg_data[0];
                vlcs_pkg::CFG_SWAP_LINE:  r_swap_line  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (!o_in_stall) begin
            r_iv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_fid   <= i_field_id;
            r_vs    <= i_vsync_active;
            r_wadc  <= i_wave_adc;
            r_ca    <= i_cv_adc_first;
            r_cb    <= i_cv_adc_second;
            r_cc    <= i_cv_adc_third;
            r_trig  <= i_trigger_level;
            r_rdone <= i_render_done;
        end
    end

    assign line_inc  = (r_line_cnt  == vlcs_pkg::CNT16_MAX) ? r_line_cnt  : r_line_cnt + 1'b1;
    assign frame_inc = (r_frame_cnt == vlcs_pkg::CNT16_MAX) ? r_frame_cnt : r_frame_cnt + 1'b1;

    always_comb begin
        n_field_seen   = r_field_seen;
        n_frame_cnt    = frame_inc;
        n_first_lines  = r_first_lines;
        n_second_lines = r_second_lines;
        n_event        = vlcs_pkg::EV_NONE;
        if (!r_vs && r_fid && !r_field_seen && frame_inc >= vlcs_pkg::FIELD_MIN) begin
            n_first_lines = frame_inc;
            n_field_seen  = 1'b1;
            n_event       = vlcs_pkg::EV_FIRST;
        end else if (!r_vs && !r_fid && frame_inc >= vlcs_pkg::FRAME_MIN) begin
            n_field_seen   = 1'b0;
            n_second_lines = frame_inc - r_first_lines;
            n_frame_cnt    = '0;
            n_event        = vlcs_pkg::EV_FRAME;
        end

        swap          = (n_frame_cnt == r_swap_line);
        n_line_cnt    = swap ? 16'd0 : line_inc;
        n_render_flag = r_render_flag || r_rdone;
        n_smp_wr      = r_smp_wr;
        n_smp_rd      = r_smp_rd;
        n_wav_wr      = r_wav_wr;
        n_wav_rd      = r_wav_rd;
        n_dropped     = r_dropped;
        if (swap) begin
            if (n_render_flag) begin
                if (r_capture_en) begin
                    n_smp_rd = r_smp_wr;
                    n_smp_wr = vlcs_pkg::next_buf(r_smp_wr);
                end
                n_wav_rd      = r_wav_wr;
                n_wav_wr      = vlcs_pkg::next_buf(r_wav_wr);
                n_render_flag = 1'b0;
            end else if (r_dropped != vlcs_pkg::CNT32_MAX) begin
                n_dropped = r_dropped + 1'b1;
            end
        end

        n_rises = r_rises;
        n_falls = r_falls;
        if (r_trig && !r_trig_prev) begin
            n_rises = r_rises + 1'b1;
        end else if (!r_trig && r_trig_prev) begin
            n_falls = r_falls + 1'b1;
        end

        smooth_ctl.en = fire;
        if (n_line_cnt == 16'd0) begin
            smooth_ctl.mode = vlcs_pkg::SM_RAW;
        end else if (n_line_cnt < 16'd3) begin
            smooth_ctl.mode = vlcs_pkg::SM_PAIR;
        end else begin
            smooth_ctl.mode = vlcs_pkg::SM_QUAD;
        end
    end

    assign wave_cond = vlcs_pkg::wave_cond(r_wadc);
    assign cv_cond   = vlcs_pkg::cv_cond(r_ca, r_cb, r_cc);

    vlcs_smooth u_wave_smooth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (smooth_ctl),
        .i_value  (wave_cond),
        .o_result (wave_sm)
    );

    vlcs_smooth u_cv_smooth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (smooth_ctl),
        .i_value  (cv_cond),
        .o_result (cv_sm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_seen   <= 1'b0;
            r_frame_cnt    <= '0;
            r_line_cnt     <= '0;
            r_smp_wr       <= '0;
            r_smp_rd       <= '0;
            r_wav_wr       <= '0;
            r_wav_rd       <= '0;
            r_render_flag  <= 1'b0;
            r_dropped      <= '0;
            r_first_lines  <= '0;
            r_second_lines <= '0;
            r_trig_prev    <= 1'b0;
            r_rises        <= '0;
            r_falls        <= '0;
        end else if (fire) begin
            r_field_seen   <= n_field_seen;
            r_frame_cnt    <= n_frame_cnt;
            r_line_cnt     <= n_line_cnt;
            r_smp_wr       <= n_smp_wr;
            r_smp_rd       <= n_smp_rd;
            r_wav_wr       <= n_wav_wr;
            r_wav_rd       <= n_wav_rd;
            r_render_flag  <= n_render_flag;
            r_dropped      <= n_dropped;
            r_first_lines  <= n_first_lines;
            r_second_lines <= n_second_lines;
            r_trig_prev    <= r_trig;
            r_rises        <= n_rises;
            r_falls        <= n_falls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_iv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_line_index         <= n_line_cnt;
            o_sample_buffer      <= 2'(n_smp_wr);
            o_wave_value         <= wave_sm;
            o_cv_value           <= cv_sm;
            o_wave_read_buffer   <= 2'(n_wav_rd);
            o_sample_read_buffer <= 2'(n_smp_rd);
            o_field_event        <= n_event;
            o_lines_first_field  <= n_first_lines;
            o_lines_second_field <= n_second_lines;
            o_missed_swaps       <= n_dropped;
            o_trigger_rises      <= n_rises;
            o_trigger_falls      <= n_falls;
        end
    end

`ifndef SYNTHESIS
    // a frame end always leaves the frame count cleared
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && n_event == vlcs_pkg::EV_FRAME) |=> (r_frame_cnt == 16'd0))
        else $error("frame count not cleared at frame end");

    // the swap line restarts the line index
    a_swap_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && swap) |=> (r_line_cnt == 16'd0 && o_line_index == 16'd0))
        else $error("line index not restarted at swap");

    // input side only stalls with a line waiting in the input register
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_iv && r_ov))
        else $error("input stalled with room in the pipeline");

    // a rotation moves the read buffer onto the old write buffer
    a_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && swap && n_render_flag == 1'b0 && r_render_flag | r_rdone)
            |=> (r_wav_rd == $past(r_wav_wr)))
        else $error("wave read buffer did not follow write buffer");
`endif

endmodule

`default_nettype wire
